>>> rtl/aes128_pkg.sv
// Shared types, constants and byte functions for the AES-128 encrypt pipeline.
// No dependencies; imported by every module in rtl/.
`default_nettype none
package aes128_pkg;

	localparam int NumRounds = 10;

	typedef struct packed {
		logic [63:0] plain_high;
		logic [63:0] plain_low;
	} aes128_in_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} aes128_out_t;

	typedef enum logic {
		KEY_HIGH = 1'b0,
		KEY_LOW  = 1'b1
	} aes128_reg_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
		8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
		8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
		8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
		8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
		8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
		8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
		8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
		8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
		8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
		8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
		8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
		8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
		8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
		8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
		8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
		8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
		8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
		8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
		8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
		8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
		8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
		8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
		8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
		8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
		8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
		8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
		8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
		8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
		8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
	};

	localparam logic [7:0] RCON [NumRounds] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	// Multiply by x modulo the field polynomial.
	function automatic logic [7:0] xtime(input logic [7:0] x);
		xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a 128-bit state sits in bits 127-8i down to 120-8i.
	function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
		get_byte = s[127 - 8 * i -: 8];
	endfunction

endpackage
`default_nettype wire

>>> rtl/aes128_block_encrypt_unit.sv
// AES-128 block encrypt, fully unrolled: key add stage plus ten round stages.
// Pipeline: 11 register stages; a block passes through the key add stage and then
// round stages 1 to 10 in turn, and out_valid rises once it reaches the last.
// Throughput: one block per cycle while out_stall is low; each stage holds or advances
// on its own, so bubbles close up while the output is stalled.
// Reset clears all stage valid bits and both key registers to zero.
// Depends on aes128_pkg, aes128_round and aes128_lane.
`default_nettype none
module aes128_block_encrypt_unit
	import aes128_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire aes128_in_t  in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output aes128_out_t      out_data
);

	logic [63:0]  key_high_q, key_low_q;
	logic [NumRounds:0] valid_s;
	logic [NumRounds:0] load;
	logic [127:0] state_s [NumRounds + 1];
	logic [127:0] key_s   [NumRounds + 1];

	// Write key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				KEY_HIGH: key_high_q <= cfg_data;
				KEY_LOW:  key_low_q  <= cfg_data;
				default:  key_high_q <= key_high_q;
			endcase
		end
	end

	// Advance a stage when it is empty or the next one advances
	always_comb begin
		load[NumRounds] = !valid_s[NumRounds] || !out_stall;
		for (int i = NumRounds - 1; i >= 0; i--) begin
			load[i] = !valid_s[i] || load[i + 1];
		end
	end

	assign in_stall = !load[0];

	// Initial key add stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (load[0]) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			state_s[0] <= {in_data.plain_high, in_data.plain_low} ^ {key_high_q, key_low_q};
			key_s[0]   <= {key_high_q, key_low_q};
		end
	end

	for (genvar r = 1; r <= NumRounds; r++) begin : g_round
		aes128_round #(
			.Round(r)
		) u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (load[r]),
			.valid_in(valid_s[r - 1]),
			.state_in(state_s[r - 1]),
			.key_in  (key_s[r - 1]),
			.valid_q (valid_s[r]),
			.state_q (state_s[r]),
			.key_q   (key_s[r])
		);
	end

	assign out_valid = valid_s[NumRounds];
	assign out_data  = aes128_out_t'(state_s[NumRounds]);

	// An input transfer always lands in the first stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s[0])
		else $error("input transfer lost");

	// An empty first stage never stalls the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s[0] |-> !in_stall)
		else $error("stall with empty first stage");

	// A stalled result stays in the output stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(state_s[NumRounds])))
		else $error("stalled result dropped");

endmodule
`default_nettype wire

>>> rtl/aes128_lane.sv
// One column lane: SubBytes on four already-shifted bytes, then MixColumns
// unless this is the last round. Depends on aes128_pkg.
`default_nettype none
module aes128_lane
	import aes128_pkg::*;
#(
	parameter bit LastRound = 1'b0
) (
	input  wire logic [31:0] col_in,
	output logic      [31:0] col_out
);

	logic [7:0] a0, a1, a2, a3, all;

	// Substitute each byte of the column
	always_comb begin
		a0 = SBOX[col_in[31:24]];
		a1 = SBOX[col_in[23:16]];
		a2 = SBOX[col_in[15:8]];
		a3 = SBOX[col_in[7:0]];
		all = a0 ^ a1 ^ a2 ^ a3;
	end

	// Mix the column, or pass it through in the final round
	always_comb begin
		if (LastRound) begin
			col_out = {a0, a1, a2, a3};
		end else begin
			col_out = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
				a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
		end
	end

endmodule
`default_nettype wire

>>> rtl/aes128_round.sv
// One pipelined cipher round: four column lanes, round key expansion, and a
// merge stage that applies AddRoundKey into the stage register.
// Depends on aes128_pkg and aes128_lane.
`default_nettype none
module aes128_round
	import aes128_pkg::*;
#(
	parameter int Round = 1
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         load,
	input  wire logic         valid_in,
	input  wire logic [127:0] state_in,
	input  wire logic [127:0] key_in,
	output logic              valid_q,
	output logic      [127:0] state_q,
	output logic      [127:0] key_q
);

	logic [127:0] shifted;
	logic [127:0] lanes;
	logic [127:0] rkey;
	logic [31:0]  rot_word;

	// Route ShiftRows: lane c row r takes byte 4*((c+r)&3)+r
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				shifted[127 - 8 * (4 * c + r) -: 8] = get_byte(state_in, 4 * ((c + r) % 4) + r);
			end
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_lane
		aes128_lane #(
			.LastRound(Round == NumRounds)
		) u_lane (
			.col_in (shifted[127 - 32 * c -: 32]),
			.col_out(lanes[127 - 32 * c -: 32])
		);
	end

	// Expand the next round key from the previous one
	always_comb begin
		rot_word = {SBOX[get_byte(key_in, 13)] ^ RCON[Round - 1], SBOX[get_byte(key_in, 14)],
			SBOX[get_byte(key_in, 15)], SBOX[get_byte(key_in, 12)]};
		rkey[127:96] = key_in[127:96] ^ rot_word;
		rkey[95:64]  = key_in[95:64] ^ rkey[127:96];
		rkey[63:32]  = key_in[63:32] ^ rkey[95:64];
		rkey[31:0]   = key_in[31:0] ^ rkey[63:32];
	end

	// Hold the stage valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= valid_in;
		end
	end

	// Merge lanes with the round key
	always_ff @(posedge clk) begin
		if (load) begin
			state_q <= lanes ^ rkey;
			key_q   <= rkey;
		end
	end

endmodule
`default_nettype wire
